// ===== sv/ip_packet_checksum_top_defines.svh =====
// Assertion macros shared by the checksum block; clocked on clk, disabled in reset.
`ifndef IP_PACKET_CHECKSUM_TOP_DEFINES_SVH
`define IP_PACKET_CHECKSUM_TOP_DEFINES_SVH

// Same-cycle implication.
`define IPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IPC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ipc_pkg.sv =====
// Types, constants and the ones' complement adder of the IP checksum block.
`timescale 1ns / 1ps

package ipc_pkg;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_IPV6_MODE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MODE  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_HDR     = 8'd3;

	localparam logic [15:0] HDR_V4     = 16'd20;
	localparam logic [15:0] HDR_V6     = 16'd40;
	localparam logic [15:0] LEN_HI_V4  = 16'd2;
	localparam logic [15:0] LEN_HI_V6  = 16'd4;
	localparam logic [15:0] ADDR_LO_V4 = 16'd12;
	localparam logic [15:0] ADDR_LO_V6 = 16'd8;
	localparam logic [15:0] OFFSET_MAX = 16'hffff;
	localparam logic [15:0] SUM_ZERO_MAP = 16'hffff;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BAD_LEN = 2'd2
	} status_t;

	// 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== sv/ipc_ifs.sv =====
// Valid/ready channel interfaces: packet bytes in, results out, register writes.
`timescale 1ns / 1ps

interface ipc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       eop;

	modport source (output valid, output data_byte, output eop, input ready);
	modport sink   (input valid, input data_byte, input eop, output ready);
endinterface

interface ipc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic [1:0]  status;

	modport source (output valid, output checksum, output status, input ready);
	modport sink   (input valid, input checksum, input status, output ready);
endinterface

interface ipc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ip_packet_checksum_top.sv =====
// Streaming IP header / pseudo-header checksum engine, one packet byte per transfer.
// Path: a transferred byte is held in the input register, then folded into the sum; for the
//   last byte the result register loads instead (two-stage path).
// Throughput: one byte per cycle, set by the single input register and the sum update;
//   a last byte waits in the input register only while an older result is held untaken.
// Reset (arst_n low, asynchronous): registers return to ipv6_mode=1, upper_layer_mode=1,
//   protocol=6, ext_header_bytes=0; packet state and both stages are emptied at once.
`timescale 1ns / 1ps
`include "ip_packet_checksum_top_defines.svh"

module ip_packet_checksum_top import ipc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ipc_cfg_if.sink    cfg,
	ipc_in_if.sink     pkt,
	ipc_out_if.source  res
);

	// ---------------------------------------------------------------------------
	// Configuration registers. Writes are always taken; unknown indexes drop.
	// ---------------------------------------------------------------------------
	logic       ipv6_mode_q;
	logic       upper_mode_q;
	logic [7:0] protocol_q;
	logic [7:0] ext_hdr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv6_mode_q  <= 1'b1;
			upper_mode_q <= 1'b1;
			protocol_q   <= 8'd6;
			ext_hdr_q    <= 8'd0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IPV6_MODE:  ipv6_mode_q  <= cfg.data[0];
				CFG_UPPER_MODE: upper_mode_q <= cfg.data[0];
				CFG_PROTOCOL:   protocol_q   <= cfg.data;
				CFG_EXT_HDR:    ext_hdr_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 1: input register. It advances every cycle unless it holds a last
	// byte and the result register is still occupied by an untaken result.
	// ---------------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	logic        out_valid_q;
	logic [15:0] out_checksum_q;
	logic [1:0]  out_status_q;

	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.data_byte;
			last_s1 <= pkt.eop;
		end
	end

	// ---------------------------------------------------------------------------
	// Packet state.
	// ---------------------------------------------------------------------------
	logic [15:0] sum_q;
	logic [15:0] offset_q;
	logic [7:0]  held_q;
	logic        pending_q;
	logic [15:0] plen_q;
	logic        len_bad_q;

	logic [15:0] sum_nx;
	logic [15:0] offset_nx;
	logic [7:0]  held_nx;
	logic        pending_nx;
	logic [15:0] plen_nx;
	logic        len_bad_nx;

	// Layout of the current mode.
	logic [15:0] hdr;
	logic [15:0] len_hi;
	logic [15:0] addr_lo;
	logic [15:0] pstart;
	logic [16:0] region_end;
	logic [16:0] region_end_nx;
	logic [15:0] raw_len;
	logic [15:0] len_sub;
	logic        in_range;
	logic        feed_hdr;
	logic        feed_pay;
	logic        pad_last;
	status_t     status_nx;
	logic [15:0] checksum_nx;

	assign hdr     = ipv6_mode_q ? HDR_V6 : HDR_V4;
	assign len_hi  = ipv6_mode_q ? LEN_HI_V6 : LEN_HI_V4;
	assign addr_lo = ipv6_mode_q ? ADDR_LO_V6 : ADDR_LO_V4;
	assign pstart  = hdr + (ipv6_mode_q ? {8'd0, ext_hdr_q} : 16'd0);

	// Payload bound from the stored length; in upper-layer mode the length bytes never feed.
	assign region_end    = {1'b0, pstart} + {1'b0, plen_q};
	assign region_end_nx = {1'b0, pstart} + {1'b0, plen_nx};

	assign raw_len  = {plen_q[15:8], byte_s1};
	assign len_sub  = ipv6_mode_q ? {8'd0, ext_hdr_q} : HDR_V4;
	assign in_range = (offset_q != OFFSET_MAX);

	// Header mode sums the fixed header; upper-layer mode sums the addresses.
	assign feed_hdr = in_range && (upper_mode_q
		? (offset_q >= addr_lo && offset_q < hdr)
		: (offset_q < hdr));
	assign feed_pay = in_range && upper_mode_q
		&& ({1'b0, offset_q} >= {1'b0, pstart}) && ({1'b0, offset_q} < region_end);
	// Final payload byte: an odd one goes out padded with a zero low byte.
	assign pad_last = feed_pay && ({1'b0, offset_q} == region_end - 17'd1);

	always_comb begin
		sum_nx     = sum_q;
		offset_nx  = offset_q;
		held_nx    = held_q;
		pending_nx = pending_q;
		plen_nx    = plen_q;
		len_bad_nx = len_bad_q;

		if (in_range) begin
			offset_nx = offset_q + 16'd1;
		end

		// Length field: high byte, then low byte with the pseudo-header words.
		if (in_range && upper_mode_q) begin
			if (offset_q == len_hi) begin
				plen_nx = {byte_s1, 8'd0};
			end else if (offset_q == len_hi + 16'd1) begin
				if (raw_len < len_sub) begin
					len_bad_nx = 1'b1;
					plen_nx    = 16'd0;
				end else begin
					plen_nx = raw_len - len_sub;
				end
				sum_nx = oc_add(oc_add(sum_q, plen_nx), {8'd0, protocol_q});
			end
		end

		// Pair bytes big-endian; a full word goes into the sum.
		if (feed_hdr || feed_pay) begin
			if (pending_q) begin
				sum_nx     = oc_add(sum_q, {held_q, byte_s1});
				pending_nx = 1'b0;
			end else if (pad_last) begin
				sum_nx = oc_add(sum_q, {byte_s1, 8'd0});
			end else begin
				held_nx    = byte_s1;
				pending_nx = 1'b1;
			end
		end
	end

	// Status from the state this byte leaves behind.
	always_comb begin
		if (!upper_mode_q) begin
			status_nx = (offset_nx < hdr) ? ST_SHORT : ST_OK;
		end else if (offset_nx < len_hi + 16'd2) begin
			status_nx = ST_SHORT;
		end else if (len_bad_nx) begin
			status_nx = ST_BAD_LEN;
		end else if ({1'b0, offset_nx} < region_end_nx) begin
			status_nx = ST_SHORT;
		end else begin
			status_nx = ST_OK;
		end
	end

	// A zero sum reads as all ones; any error zeroes the checksum.
	assign checksum_nx = (status_nx != ST_OK) ? 16'd0
		: ((sum_nx == 16'd0) ? SUM_ZERO_MAP : sum_nx);

	// Advance the packet state; the last byte clears it for the next packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			offset_q  <= '0;
			held_q    <= '0;
			pending_q <= 1'b0;
			plen_q    <= '0;
			len_bad_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				sum_q     <= '0;
				offset_q  <= '0;
				held_q    <= '0;
				pending_q <= 1'b0;
				plen_q    <= '0;
				len_bad_q <= 1'b0;
			end else begin
				sum_q     <= sum_nx;
				offset_q  <= offset_nx;
				held_q    <= held_nx;
				pending_q <= pending_nx;
				plen_q    <= plen_nx;
				len_bad_q <= len_bad_nx;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Result register: loads on a last byte, drops once the transfer completes.
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_checksum_q <= checksum_nx;
			out_status_q   <= status_nx;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.checksum = out_checksum_q;
	assign res.status   = out_status_q;

	// ---------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------
	`IPC_ASSERT_IMP(a_err_zero_sum, out_valid_q && out_status_q != ST_OK,
		out_checksum_q == 16'd0, "error result carries a nonzero checksum")
	`IPC_ASSERT_IMP(a_ok_nonzero, out_valid_q && out_status_q == ST_OK,
		out_checksum_q != 16'd0, "ok result carries a zero checksum")
	`IPC_ASSERT_NXT(a_clear_after_last, advance && last_s1,
		offset_q == 16'd0 && !pending_q && sum_q == 16'd0 && !len_bad_q,
		"packet state not cleared after last byte")
	`IPC_ASSERT_NXT(a_stall_holds_s1, valid_s1 && !advance,
		valid_s1 && last_s1 && $stable(byte_s1), "stalled input stage lost its byte")

endmodule
